// ===== sv/owsce_pkg.sv =====
// ----------------------------------------------------------------------------
// One-wire slave command engine: shared package
// Types, register indexes, opcode ranges and helpers for the slot engine.
// ----------------------------------------------------------------------------
package owsce_pkg;

   // Configuration register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROM_ID       = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCRATCH_LOW  = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_SCRATCH_HIGH = 2'd2;

   localparam logic [63:0] ROM_ID_RESET       = 64'h0002_0000_0000_0028;
   localparam logic [63:0] SCRATCH_LOW_RESET  = 64'h1007_FF7F_464B_0179;
   localparam logic [7:0]  SCRATCH_HIGH_RESET = 8'h70;

   // Bit counts per phase
   localparam logic [6:0] CMD_BITS     = 7'd8;
   localparam logic [6:0] ROM_BITS     = 7'd64;
   localparam logic [6:0] SCRATCH_BITS = 7'd72;

   // Tolerant opcode ranges
   localparam logic [7:0] OP_READ_ROM_LO   = 8'h31;
   localparam logic [7:0] OP_READ_ROM_HI   = 8'h35;
   localparam logic [7:0] OP_SEARCH_LO     = 8'hEC;
   localparam logic [7:0] OP_SEARCH_HI     = 8'hF4;
   localparam logic [7:0] OP_MATCH_LO      = 8'h53;
   localparam logic [7:0] OP_MATCH_HI      = 8'h57;
   localparam logic [7:0] OP_SKIP_LO       = 8'hCA;
   localparam logic [7:0] OP_SKIP_HI       = 8'hCE;
   localparam logic [7:0] OP_CONVERT_LO    = 8'h42;
   localparam logic [7:0] OP_CONVERT_HI    = 8'h46;
   localparam logic [7:0] OP_READ_SCR_LO   = 8'hBA;
   localparam logic [7:0] OP_READ_SCR_HI   = 8'hC3;

   // Search sub-slots
   localparam logic [1:0] SUB_BIT    = 2'd0;
   localparam logic [1:0] SUB_INV    = 2'd1;
   localparam logic [1:0] SUB_CHOICE = 2'd2;

   // Phase codes as shown on the result
   localparam logic [2:0] CODE_IDLE    = 3'd0;
   localparam logic [2:0] CODE_ROMCMD  = 3'd1;
   localparam logic [2:0] CODE_READROM = 3'd2;
   localparam logic [2:0] CODE_SEARCH  = 3'd3;
   localparam logic [2:0] CODE_MATCH   = 3'd4;
   localparam logic [2:0] CODE_FNCMD   = 3'd5;
   localparam logic [2:0] CODE_SCRATCH = 3'd6;

   typedef enum logic [6:0] {
      PH_IDLE    = 7'b0000001,
      PH_ROMCMD  = 7'b0000010,
      PH_READROM = 7'b0000100,
      PH_SEARCH  = 7'b0001000,
      PH_MATCH   = 7'b0010000,
      PH_FNCMD   = 7'b0100000,
      PH_SCRATCH = 7'b1000000
   } phase_type;

   typedef struct packed {
      logic action;
      logic master_bit;
   } req_type;

   typedef struct packed {
      logic       drive_low;
      logic       presence;
      logic [2:0] phase_now;
      logic       data_ready;
   } rsp_type;

   typedef struct packed {
      logic [63:0] rom_id;
      logic [63:0] scratch_low;
      logic [7:0]  scratch_high;
   } cfg_type;

   typedef struct packed {
      phase_type  phase;
      logic [6:0] bit_count;
      logic [1:0] search_sub;
      logic [7:0] command_shift;
      logic       ready_flag;
   } state_type;

   function automatic logic in_range(input logic [7:0] v, input logic [7:0] lo,
                                     input logic [7:0] hi);
      return (v >= lo) && (v <= hi);
   endfunction

   // Enter a phase with counters and shift register cleared
   function automatic state_type enter_phase(input phase_type p, input logic ready);
      state_type s;
      s.phase         = p;
      s.bit_count     = '0;
      s.search_sub    = SUB_BIT;
      s.command_shift = '0;
      s.ready_flag    = ready;
      return s;
   endfunction

   function automatic phase_type rom_target(input logic [7:0] op);
      phase_type p;
      if (in_range(op, OP_READ_ROM_LO, OP_READ_ROM_HI)) begin
         p = PH_READROM;
      end else if (in_range(op, OP_SEARCH_LO, OP_SEARCH_HI)) begin
         p = PH_SEARCH;
      end else if (in_range(op, OP_MATCH_LO, OP_MATCH_HI)) begin
         p = PH_MATCH;
      end else if (in_range(op, OP_SKIP_LO, OP_SKIP_HI)) begin
         p = PH_FNCMD;
      end else begin
         p = PH_IDLE;
      end
      return p;
   endfunction

   function automatic logic [2:0] phase_code(input phase_type p);
      logic [2:0] c;
      case (p)
         PH_ROMCMD:  c = CODE_ROMCMD;
         PH_READROM: c = CODE_READROM;
         PH_SEARCH:  c = CODE_SEARCH;
         PH_MATCH:   c = CODE_MATCH;
         PH_FNCMD:   c = CODE_FNCMD;
         PH_SCRATCH: c = CODE_SCRATCH;
         default:    c = CODE_IDLE;
      endcase
      return c;
   endfunction

endpackage

// ===== sv/owsce_csr.sv =====
// ----------------------------------------------------------------------------
// One-wire slave command engine: configuration registers
// Serial number and scratchpad contents, written through a plain write port.
// ----------------------------------------------------------------------------
module owsce_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write,
   input  logic [owsce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                        csr_data,
   output owsce_pkg::cfg_type                 cfg
);

   owsce_pkg::cfg_type cfg_ff;
   owsce_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_index)
            owsce_pkg::CSR_ROM_ID:       cfg_in.rom_id       = csr_data;
            owsce_pkg::CSR_SCRATCH_LOW:  cfg_in.scratch_low  = csr_data;
            owsce_pkg::CSR_SCRATCH_HIGH: cfg_in.scratch_high = csr_data[7:0];
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.rom_id       <= owsce_pkg::ROM_ID_RESET;
         cfg_ff.scratch_low  <= owsce_pkg::SCRATCH_LOW_RESET;
         cfg_ff.scratch_high <= owsce_pkg::SCRATCH_HIGH_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== sv/owsce_step.sv =====
// ----------------------------------------------------------------------------
// One-wire slave command engine: slot decision logic
// Works out the drive decision and next engine state for one bus slot.
// ----------------------------------------------------------------------------
module owsce_step (
   input  owsce_pkg::state_type cur,
   input  owsce_pkg::req_type   req,
   input  owsce_pkg::cfg_type   cfg,
   output owsce_pkg::state_type nxt,
   output owsce_pkg::rsp_type   rsp
);

   logic [7:0] shifted;
   logic [6:0] count_inc;
   logic       rom_b;
   logic       scr_b;
   logic       drive;
   logic       pres;

   assign shifted   = {req.master_bit, cur.command_shift[7:1]};
   assign count_inc = cur.bit_count + 7'd1;
   assign rom_b     = cfg.rom_id[cur.bit_count[5:0]];
   // ninth byte once the count reaches 64
   assign scr_b     = cur.bit_count[6] ? cfg.scratch_high[cur.bit_count[2:0]]
                                       : cfg.scratch_low[cur.bit_count[5:0]];

   always_comb begin
      nxt   = cur;
      drive = 1'b0;
      pres  = 1'b0;
      if (!req.action) begin
         nxt   = owsce_pkg::enter_phase(owsce_pkg::PH_ROMCMD, cur.ready_flag);
         drive = 1'b1;
         pres  = 1'b1;
      end else begin
         case (cur.phase)
            owsce_pkg::PH_IDLE: begin
               nxt = cur;
            end
            owsce_pkg::PH_ROMCMD: begin
               nxt.command_shift = shifted;
               nxt.bit_count     = count_inc;
               if (count_inc >= owsce_pkg::CMD_BITS) begin
                  nxt = owsce_pkg::enter_phase(owsce_pkg::rom_target(shifted),
                                               cur.ready_flag);
               end
            end
            owsce_pkg::PH_FNCMD: begin
               nxt.command_shift = shifted;
               nxt.bit_count     = count_inc;
               if (count_inc >= owsce_pkg::CMD_BITS) begin
                  if (owsce_pkg::in_range(shifted, owsce_pkg::OP_CONVERT_LO,
                                          owsce_pkg::OP_CONVERT_HI)) begin
                     nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, 1'b1);
                  end else if (owsce_pkg::in_range(shifted, owsce_pkg::OP_READ_SCR_LO,
                                                   owsce_pkg::OP_READ_SCR_HI)
                               && cur.ready_flag) begin
                     nxt = owsce_pkg::enter_phase(owsce_pkg::PH_SCRATCH, cur.ready_flag);
                  end else begin
                     nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, cur.ready_flag);
                  end
               end
            end
            owsce_pkg::PH_READROM: begin
               drive         = ~rom_b;
               nxt.bit_count = count_inc;
               if (count_inc >= owsce_pkg::ROM_BITS) begin
                  nxt = owsce_pkg::enter_phase(owsce_pkg::PH_FNCMD, cur.ready_flag);
               end
            end
            owsce_pkg::PH_SEARCH: begin
               case (cur.search_sub)
                  owsce_pkg::SUB_BIT: begin
                     drive          = ~rom_b;
                     nxt.search_sub = owsce_pkg::SUB_INV;
                  end
                  owsce_pkg::SUB_INV: begin
                     drive          = rom_b;
                     nxt.search_sub = owsce_pkg::SUB_CHOICE;
                  end
                  default: begin
                     nxt.search_sub = owsce_pkg::SUB_BIT;
                     nxt.bit_count  = count_inc;
                     // drop out on a lost arbitration or when all bits are done
                     if ((req.master_bit != rom_b) || (count_inc >= owsce_pkg::ROM_BITS)) begin
                        nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, cur.ready_flag);
                     end
                  end
               endcase
            end
            owsce_pkg::PH_MATCH: begin
               nxt.bit_count = count_inc;
               if (req.master_bit != rom_b) begin
                  nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, cur.ready_flag);
               end else if (count_inc >= owsce_pkg::ROM_BITS) begin
                  nxt = owsce_pkg::enter_phase(owsce_pkg::PH_FNCMD, cur.ready_flag);
               end
            end
            owsce_pkg::PH_SCRATCH: begin
               drive         = ~scr_b;
               nxt.bit_count = count_inc;
               if (count_inc >= owsce_pkg::SCRATCH_BITS) begin
                  nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, 1'b0);
               end
            end
            default: begin
               nxt = owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, cur.ready_flag);
            end
         endcase
      end
   end

   always_comb begin
      rsp.drive_low  = drive;
      rsp.presence   = pres;
      rsp.phase_now  = owsce_pkg::phase_code(nxt.phase);
      rsp.data_ready = nxt.ready_flag;
   end

endmodule

// ===== sv/onewire_slave_command_engine_core.sv =====
// Takes one bus slot (reset pulse or time slot) per clock, unless req_stall
// holds it, and returns one result per slot. A slot taken at a clock edge
// lands in the input register, and its result is offered on the result
// channel from the result register when the result side is not stalling.
// The decision logic works out the drive level and the next engine state
// from the held slot, and the outcome is held in the result register until
// it is transferred. The engine state moves on as each slot passes into the
// result register, so slots may follow in every cycle while nothing stalls.
// Configuration registers reset to the default serial number and scratchpad;
// the user must write them only while no slot is in flight (not enforced).
// ----------------------------------------------------------------------------
// One-wire slave command engine: top level
// Input register, slot decision logic, engine state and result register.
// ----------------------------------------------------------------------------
module onewire_slave_command_engine_core (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  owsce_pkg::req_type                 req_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output owsce_pkg::rsp_type                 rsp_data,
   input  logic                               csr_write,
   input  logic [owsce_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [63:0]                        csr_data
);

   owsce_pkg::cfg_type   cfg;
   owsce_pkg::state_type state_ff;
   owsce_pkg::state_type state_in;
   owsce_pkg::rsp_type   step_rsp;

   logic               in_valid_ff;
   owsce_pkg::req_type in_data_ff;
   logic               rsp_valid_ff;
   owsce_pkg::rsp_type rsp_data_ff;
   logic               advance;

   owsce_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   owsce_step u_step (
      .cur (state_ff),
      .req (in_data_ff),
      .cfg (cfg),
      .nxt (state_in),
      .rsp (step_rsp)
   );

   // move the held slot on when the result register is free or emptying
   assign advance   = in_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         state_ff     <= owsce_pkg::enter_phase(owsce_pkg::PH_IDLE, 1'b1);
      end else begin
         if (!req_stall) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
            state_ff     <= state_in;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_data_ff <= req_data;
      end
      if (advance) begin
         rsp_data_ff <= step_rsp;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== sv/owsce_checker.sv =====
// ----------------------------------------------------------------------------
// One-wire slave command engine: port checker
// Watches the result channel of the top level and flags broken behaviour.
// ----------------------------------------------------------------------------
module owsce_checker (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               rsp_valid,
   input  logic                               rsp_stall,
   input  owsce_pkg::rsp_type                 rsp_data
);

   // a stalled result holds until transferred
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed or vanished while stalled");

   // presence always pulls low and opens the ROM command phase
   a_presence: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.presence |->
         rsp_data.drive_low && (rsp_data.phase_now == owsce_pkg::CODE_ROMCMD))
      else $error("presence without low drive or ROM command phase");

   // the unused phase code never shows
   a_phase_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.phase_now != 3'd7))
      else $error("illegal phase code on result");

   // scratchpad is only sent while the ready flag is set
   a_scratch_ready: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_data.phase_now == owsce_pkg::CODE_SCRATCH) |-> rsp_data.data_ready)
      else $error("scratchpad phase without ready flag");

endmodule

bind onewire_slave_command_engine_core owsce_checker u_owsce_checker (.*);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// One-wire slave command engine: regression testbench
// Feeds reset pulses and time slots through the request channel with random
// idling on both sides, forecasts every result from a slot-level model of the
// engine and checks each result transfer against the oldest forecast.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned TAIL_CYCLES    = 8;
   localparam int unsigned HOLD_AT_RESULT = 600;
   localparam int unsigned HOLD_CYCLES    = 200;
   localparam logic [owsce_pkg::CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam logic ACT_RESET = 1'b0;
   localparam logic ACT_SLOT  = 1'b1;

   typedef enum int unsigned {RK_READ, RK_SEARCH, RK_MATCH, RK_SKIP, RK_BAD} rom_kind_type;
   typedef enum int unsigned {FK_CONVERT, FK_READ_SCR, FK_BAD} fn_kind_type;

   logic                              clock     = 1'b0;
   logic                              reset     = 1'b1;
   logic                              req_valid = 1'b0;
   logic                              req_stall;
   owsce_pkg::req_type                req_data  = '0;
   logic                              rsp_valid;
   logic                              rsp_stall = 1'b0;
   owsce_pkg::rsp_type                rsp_data;
   logic                              csr_write = 1'b0;
   logic [owsce_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [63:0]                       csr_data  = '0;

   // Engine copy: configuration and slot state
   logic [63:0] cfg_rom      = owsce_pkg::ROM_ID_RESET;
   logic [63:0] cfg_scr_low  = owsce_pkg::SCRATCH_LOW_RESET;
   logic [7:0]  cfg_scr_high = owsce_pkg::SCRATCH_HIGH_RESET;
   logic [2:0]  eng_phase    = owsce_pkg::CODE_IDLE;
   logic [6:0]  eng_count    = '0;
   logic [1:0]  eng_sub      = owsce_pkg::SUB_BIT;
   logic [7:0]  eng_shift    = '0;
   logic        eng_ready    = 1'b1;

   owsce_pkg::req_type slot_backlog[$];
   owsce_pkg::req_type session_slots[$];
   owsce_pkg::rsp_type pending_outcomes[$];
   owsce_pkg::rsp_type oldest;
   int unsigned error_count  = 0;
   int unsigned results_seen = 0;
   int unsigned cycle_count  = 0;
   int unsigned tx_gap_left  = 0;
   int unsigned rx_hold_left = 0;
   logic        tx_idle_on   = 1'b0;
   logic        rx_idle_on   = 1'b0;

   onewire_slave_command_engine_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   function automatic void go_phase(input logic [2:0] p);
      eng_phase = p;
      eng_count = '0;
      eng_sub   = owsce_pkg::SUB_BIT;
      eng_shift = '0;
   endfunction

   // Advance the engine copy by one slot and return the result it gives
   function automatic owsce_pkg::rsp_type slot_outcome(input owsce_pkg::req_type s);
      owsce_pkg::rsp_type r;
      logic               b;
      logic [7:0]         op;
      r = '0;
      if (s.action == ACT_RESET) begin
         go_phase(owsce_pkg::CODE_ROMCMD);
         r.drive_low = 1'b1;
         r.presence  = 1'b1;
      end else begin
         case (eng_phase)
            owsce_pkg::CODE_ROMCMD, owsce_pkg::CODE_FNCMD: begin
               eng_shift = {s.master_bit, eng_shift[7:1]};
               eng_count = eng_count + 7'd1;
               if (eng_count >= owsce_pkg::CMD_BITS) begin
                  op = eng_shift;
                  if (eng_phase == owsce_pkg::CODE_ROMCMD) begin
                     if (op >= owsce_pkg::OP_READ_ROM_LO
                         && op <= owsce_pkg::OP_READ_ROM_HI) begin
                        go_phase(owsce_pkg::CODE_READROM);
                     end else if (op >= owsce_pkg::OP_SEARCH_LO
                                  && op <= owsce_pkg::OP_SEARCH_HI) begin
                        go_phase(owsce_pkg::CODE_SEARCH);
                     end else if (op >= owsce_pkg::OP_MATCH_LO
                                  && op <= owsce_pkg::OP_MATCH_HI) begin
                        go_phase(owsce_pkg::CODE_MATCH);
                     end else if (op >= owsce_pkg::OP_SKIP_LO
                                  && op <= owsce_pkg::OP_SKIP_HI) begin
                        go_phase(owsce_pkg::CODE_FNCMD);
                     end else begin
                        go_phase(owsce_pkg::CODE_IDLE);
                     end
                  end else if (op >= owsce_pkg::OP_CONVERT_LO
                               && op <= owsce_pkg::OP_CONVERT_HI) begin
                     eng_ready = 1'b1;
                     go_phase(owsce_pkg::CODE_IDLE);
                  end else if (op >= owsce_pkg::OP_READ_SCR_LO
                               && op <= owsce_pkg::OP_READ_SCR_HI && eng_ready) begin
                     go_phase(owsce_pkg::CODE_SCRATCH);
                  end else begin
                     go_phase(owsce_pkg::CODE_IDLE);
                  end
               end
            end
            owsce_pkg::CODE_READROM: begin
               r.drive_low = ~cfg_rom[eng_count[5:0]];
               eng_count = eng_count + 7'd1;
               if (eng_count >= owsce_pkg::ROM_BITS) begin
                  go_phase(owsce_pkg::CODE_FNCMD);
               end
            end
            owsce_pkg::CODE_SEARCH: begin
               b = cfg_rom[eng_count[5:0]];
               if (eng_sub == owsce_pkg::SUB_BIT) begin
                  r.drive_low = ~b;
                  eng_sub = owsce_pkg::SUB_INV;
               end else if (eng_sub == owsce_pkg::SUB_INV) begin
                  r.drive_low = b;
                  eng_sub = owsce_pkg::SUB_CHOICE;
               end else begin
                  eng_sub = owsce_pkg::SUB_BIT;
                  if (s.master_bit != b) begin
                     go_phase(owsce_pkg::CODE_IDLE);
                  end else begin
                     eng_count = eng_count + 7'd1;
                     if (eng_count >= owsce_pkg::ROM_BITS) begin
                        go_phase(owsce_pkg::CODE_IDLE);
                     end
                  end
               end
            end
            owsce_pkg::CODE_MATCH: begin
               if (s.master_bit != cfg_rom[eng_count[5:0]]) begin
                  go_phase(owsce_pkg::CODE_IDLE);
               end else begin
                  eng_count = eng_count + 7'd1;
                  if (eng_count >= owsce_pkg::ROM_BITS) begin
                     go_phase(owsce_pkg::CODE_FNCMD);
                  end
               end
            end
            owsce_pkg::CODE_SCRATCH: begin
               b = (eng_count < owsce_pkg::ROM_BITS) ? cfg_scr_low[eng_count[5:0]]
                                                     : cfg_scr_high[eng_count[2:0]];
               r.drive_low = ~b;
               eng_count = eng_count + 7'd1;
               if (eng_count >= owsce_pkg::SCRATCH_BITS) begin
                  eng_ready = 1'b0;
                  go_phase(owsce_pkg::CODE_IDLE);
               end
            end
            // slots while waiting for a reset change nothing
            default: ;
         endcase
      end
      r.phase_now  = eng_phase;
      r.data_ready = eng_ready;
      return r;
   endfunction

   function automatic int unsigned gap_length();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 80) begin
         return $urandom_range(1, 3);
      end else if (r < 97) begin
         return $urandom_range(4, 12);
      end
      return $urandom_range(30, 80);
   endfunction

   function automatic void add_slot(input logic act, input logic level);
      owsce_pkg::req_type s;
      s.action     = act;
      s.master_bit = level;
      session_slots.push_back(s);
   endfunction

   function automatic void add_byte(input logic [7:0] b);
      for (int i = 0; i < 8; i++) begin
         add_slot(ACT_SLOT, b[i]);
      end
   endfunction

   function automatic int unsigned flush_session();
      int unsigned n;
      n = session_slots.size();
      while (session_slots.size() > 0) begin
         slot_backlog.push_back(session_slots.pop_front());
      end
      return n;
   endfunction

   // Range ends are picked often, any value in the range otherwise
   function automatic logic [7:0] pick_op(input logic [7:0] lo, input logic [7:0] hi);
      logic [7:0] v;
      case ($urandom_range(0, 3))
         0:       v = lo;
         1:       v = hi;
         default: v = 8'($urandom_range(lo, hi));
      endcase
      return v;
   endfunction

   // Session: reset, ROM command, body; read/match/skip add a function command
   function automatic int unsigned queue_session();
      rom_kind_type rom_kind;
      fn_kind_type  fn_kind;
      logic [7:0]   op;
      int unsigned  keep;
      int unsigned  extra;
      session_slots.delete();
      add_slot(ACT_RESET, 1'($urandom_range(0, 1)));
      case ($urandom_range(0, 9))
         0, 1:    rom_kind = RK_READ;
         2, 3:    rom_kind = RK_SEARCH;
         4, 5:    rom_kind = RK_MATCH;
         6, 7, 8: rom_kind = RK_SKIP;
         default: rom_kind = RK_BAD;
      endcase
      case (rom_kind)
         RK_READ:   op = pick_op(owsce_pkg::OP_READ_ROM_LO, owsce_pkg::OP_READ_ROM_HI);
         RK_SEARCH: op = pick_op(owsce_pkg::OP_SEARCH_LO, owsce_pkg::OP_SEARCH_HI);
         RK_MATCH:  op = pick_op(owsce_pkg::OP_MATCH_LO, owsce_pkg::OP_MATCH_HI);
         RK_SKIP:   op = pick_op(owsce_pkg::OP_SKIP_LO, owsce_pkg::OP_SKIP_HI);
         default: begin
            case ($urandom_range(0, 4))
               0:       op = owsce_pkg::OP_READ_ROM_LO - 8'd1;
               1:       op = owsce_pkg::OP_SEARCH_HI + 8'd1;
               2:       op = owsce_pkg::OP_MATCH_LO - 8'd1;
               3:       op = owsce_pkg::OP_SKIP_HI + 8'd1;
               default: op = 8'($urandom_range(0, 255));
            endcase
         end
      endcase
      add_byte(op);
      case (rom_kind)
         RK_READ: begin
            for (int i = 0; i < 64; i++) begin
               add_slot(ACT_SLOT, 1'($urandom_range(0, 1)));
            end
         end
         RK_SEARCH: begin
            for (int i = 0; i < 64; i++) begin
               add_slot(ACT_SLOT, 1'($urandom_range(0, 1)));
               add_slot(ACT_SLOT, 1'($urandom_range(0, 1)));
               add_slot(ACT_SLOT, cfg_rom[i] ^ ($urandom_range(0, 79) == 0));
            end
         end
         RK_MATCH: begin
            for (int i = 0; i < 64; i++) begin
               add_slot(ACT_SLOT, cfg_rom[i] ^ ($urandom_range(0, 59) == 0));
            end
         end
         default: ;
      endcase
      if (rom_kind == RK_READ || rom_kind == RK_MATCH || rom_kind == RK_SKIP) begin
         case ($urandom_range(0, 7))
            0, 1, 2: fn_kind = FK_CONVERT;
            7:       fn_kind = FK_BAD;
            default: fn_kind = FK_READ_SCR;
         endcase
         case (fn_kind)
            FK_CONVERT:  op = pick_op(owsce_pkg::OP_CONVERT_LO, owsce_pkg::OP_CONVERT_HI);
            FK_READ_SCR: op = pick_op(owsce_pkg::OP_READ_SCR_LO, owsce_pkg::OP_READ_SCR_HI);
            default: begin
               case ($urandom_range(0, 2))
                  0:       op = owsce_pkg::OP_CONVERT_HI + 8'd1;
                  1:       op = owsce_pkg::OP_READ_SCR_LO - 8'd1;
                  default: op = 8'($urandom_range(0, 255));
               endcase
            end
         endcase
         add_byte(op);
         if (fn_kind == FK_READ_SCR) begin
            for (int i = 0; i < 72; i++) begin
               add_slot(ACT_SLOT, 1'($urandom_range(0, 1)));
            end
         end
      end
      // cut short now and then so the next reset lands mid-sequence
      if ($urandom_range(0, 7) == 0) begin
         keep = $urandom_range(1, session_slots.size());
         while (session_slots.size() > keep) begin
            void'(session_slots.pop_back());
         end
      end
      if ($urandom_range(0, 4) == 0) begin
         extra = $urandom_range(1, 6);
         for (int i = 0; i < extra; i++) begin
            add_slot(($urandom_range(0, 5) != 0) ? ACT_SLOT : ACT_RESET,
                     1'($urandom_range(0, 1)));
         end
      end
      return flush_session();
   endfunction

   task automatic write_csr(input logic [owsce_pkg::CSR_INDEX_W-1:0] idx,
                            input logic [63:0] value);
      @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         owsce_pkg::CSR_ROM_ID:       cfg_rom      = value;
         owsce_pkg::CSR_SCRATCH_LOW:  cfg_scr_low  = value;
         owsce_pkg::CSR_SCRATCH_HIGH: cfg_scr_high = value[7:0];
         default: ;
      endcase
   endtask

   task automatic write_all_csr(input logic [63:0] rom, input logic [63:0] lo,
                                input logic [63:0] hi);
      write_csr(owsce_pkg::CSR_ROM_ID, rom);
      write_csr(owsce_pkg::CSR_SCRATCH_LOW, lo);
      write_csr(owsce_pkg::CSR_SCRATCH_HIGH, hi);
   endtask

   task automatic wait_for_drain();
      do begin
         @(negedge clock);
      end while (slot_backlog.size() != 0 || req_valid || pending_outcomes.size() != 0);
   endtask

   task automatic run_phase(input int unsigned target, input logic tx_on, input logic rx_on);
      int unsigned queued;
      @(negedge clock);
      tx_idle_on = tx_on;
      rx_idle_on = rx_on;
      queued = 0;
      while (queued < target) begin
         queued += queue_session();
      end
      wait_for_drain();
   endtask

   task automatic check_field(input string what, input logic [2:0] want, input logic [2:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
         error_count++;
      end
   endtask

   // Request driver: forecast each transfer as it is taken
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            pending_outcomes.push_back(slot_outcome(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (tx_gap_left > 0) begin
               tx_gap_left--;
               req_valid <= 1'b0;
            end else if (slot_backlog.size() > 0) begin
               req_data  <= slot_backlog.pop_front();
               req_valid <= 1'b1;
               if (tx_idle_on && $urandom_range(0, 3) == 0) begin
                  tx_gap_left = gap_length();
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor and stall generator
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            results_seen++;
            if (pending_outcomes.size() == 0) begin
               $display("%0t: result with none expected, expected nothing, actual %h",
                        $time, rsp_data);
               error_count++;
            end else begin
               oldest = pending_outcomes.pop_front();
               check_field("drive_low", {2'b00, oldest.drive_low},
                           {2'b00, rsp_data.drive_low});
               check_field("presence", {2'b00, oldest.presence},
                           {2'b00, rsp_data.presence});
               check_field("phase_now", oldest.phase_now, rsp_data.phase_now);
               check_field("data_ready", {2'b00, oldest.data_ready},
                           {2'b00, rsp_data.data_ready});
            end
            // hold off long enough for the engine to fill and stall its input
            if (results_seen == HOLD_AT_RESULT) begin
               rx_hold_left = HOLD_CYCLES;
            end
         end
         if (rx_hold_left == 0 && rx_idle_on && $urandom_range(0, 3) == 0) begin
            rx_hold_left = gap_length();
         end
         if (rx_hold_left > 0) begin
            rx_hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("onewire_slave_command_engine_core regression: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // Directed: ignored slots before any reset, skip ROM, convert, reset
      @(negedge clock);
      session_slots.delete();
      add_slot(ACT_SLOT, 1'b0);
      add_slot(ACT_SLOT, 1'b1);
      add_slot(ACT_RESET, 1'b0);
      add_byte(owsce_pkg::OP_SKIP_HI);
      add_byte(owsce_pkg::OP_CONVERT_LO);
      add_slot(ACT_RESET, 1'b1);
      void'(flush_session());
      wait_for_drain();

      run_phase(200, 1'b1, 1'b1);

      write_all_csr('0, '0, '0);
      write_csr(CSR_SPARE, {$urandom, $urandom});
      run_phase(200, 1'b1, 1'b0);

      write_all_csr('1, '1, '1);
      run_phase(200, 1'b0, 1'b1);

      write_all_csr({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(200, 1'b0, 1'b0);

      write_all_csr({$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom});
      run_phase(300, 1'b1, 1'b1);

      repeat (TAIL_CYCLES) @(posedge clock);
      if (error_count == 0) begin
         $display("onewire_slave_command_engine_core regression: pass");
      end else begin
         $display("onewire_slave_command_engine_core regression: fail");
      end
      $finish;
   end

endmodule
